// ----- src/nts_pkg.sv -----
// Shared types and constants for the note to PWM tone settings block.
// Used by the front, the back and the top level; no dependencies.
package nts_pkg;

   // Register indexes on the configuration port
   localparam logic [1:0] CSR_SYSTEM_CLOCK = 2'd0;
   localparam logic [1:0] CSR_VOLUME       = 2'd1;
   localparam logic [1:0] CSR_TEMPO        = 2'd2;

   localparam logic [31:0] CLOCK_RESET  = 32'd8000000;
   localparam logic [9:0]  VOLUME_RESET = 10'd50;
   localparam logic [8:0]  TEMPO_RESET  = 9'd120;

   localparam logic [15:0] MAX_AUDIBLE_HZ     = 16'd20000;
   localparam logic [17:0] WHOLE_NOTE_BASE_MS = 18'd240000;

   // Divide by the period limit of 60000: shift out 32, then multiply by
   // 2^38 / 1875 rounded up; exact for any 27-bit value after the shift
   localparam logic [27:0] PRESC_RECIP = 28'd146601551;
   // Divide by the duty scale of 2000: shift out 16, then multiply by
   // 2^29 / 125 rounded up; exact for any 22-bit value after the shift
   localparam logic [22:0] DUTY_RECIP  = 23'd4294968;

   localparam int MID_DEPTH_DEFAULT = 4;
   localparam int OUT_DEPTH_DEFAULT = 2;

   // Classified note plus the configuration it runs with
   typedef struct packed {
      logic        silent;
      logic [15:0] freq;
      logic [7:0]  den;
      logic        dotted;
      logic        dzero;
      logic [8:0]  tempo;
      logic [31:0] clk;
      logic [9:0]  vol;
   } mid_type;

   // Work word carried alongside the divider pipeline
   typedef struct packed {
      mid_type     note;
      logic [17:0] whole;
      logic [18:0] dur;
      logic [16:0] p;
      logic [15:0] period;
   } work_type;

   typedef struct packed {
      logic        silent;
      logic [16:0] prescale_value;
      logic [15:0] reload_value;
      logic [15:0] compare_value;
      logic [18:0] duration_ms;
   } rsp_type;

endpackage

// ----- src/nts_fifo.sv -----
// Small synchronous queue used between front and back and on the result side.
// Depends on nothing.
module nts_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem[rd_ptr_ff];

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end
endmodule

// ----- src/nts_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with a side word.
// Depends on nothing; the whole pipe advances when en is high.
module nts_div #(
   parameter int N = 32,
   parameter int D = 16,
   parameter int S = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  logic [N-1:0] in_num,
   input  logic [D-1:0] in_den,
   input  logic [S-1:0] in_side,
   output logic         out_valid,
   output logic [N-1:0] out_quo,
   output logic [S-1:0] out_side
);
   logic         v_s [0:N];
   logic [D-1:0] r_s [0:N];
   logic [N-1:0] q_s [0:N];
   logic [N-1:0] n_s [0:N];
   logic [D-1:0] d_s [0:N];
   logic [S-1:0] s_s [0:N];

   assign v_s[0] = in_valid;
   assign r_s[0] = '0;
   assign q_s[0] = '0;
   assign n_s[0] = in_num;
   assign d_s[0] = in_den;
   assign s_s[0] = in_side;

   genvar k;
   generate
      for (k = 0; k < N; k++) begin : g_stage
         logic         valid_ff;
         logic [D-1:0] rem_ff, den_ff, rem_in;
         logic [N-1:0] quo_ff, num_ff, quo_in;
         logic [S-1:0] side_ff;
         logic [D:0]   trial, diff;
         logic         ge;

         // Shift in the next numerator bit and try a subtract
         always_comb begin
            trial  = {r_s[k], n_s[k][N-1-k]};
            diff   = trial - {1'b0, d_s[k]};
            ge     = (trial >= {1'b0, d_s[k]});
            rem_in = ge ? diff[D-1:0] : trial[D-1:0];
            quo_in = q_s[k];
            quo_in[N-1-k] = ge;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff <= 1'b0;
            end else if (en) begin
               valid_ff <= v_s[k];
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff  <= rem_in;
               quo_ff  <= quo_in;
               num_ff  <= n_s[k];
               den_ff  <= d_s[k];
               side_ff <= s_s[k];
            end
         end

         assign v_s[k+1] = valid_ff;
         assign r_s[k+1] = rem_ff;
         assign q_s[k+1] = quo_ff;
         assign n_s[k+1] = num_ff;
         assign d_s[k+1] = den_ff;
         assign s_s[k+1] = side_ff;
      end
   endgenerate

   assign out_valid = v_s[N];
   assign out_quo   = q_s[N];
   assign out_side  = s_s[N];
endmodule

// ----- src/nts_front.sv -----
// Front: configuration registers and classification of incoming notes.
// Depends on nts_pkg.
module nts_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_en,
   input  logic [1:0]      csr_index,
   input  logic [31:0]     csr_wdata,
   input  logic [15:0]     req_note_frequency,
   input  logic [7:0]      req_note_divider,
   output nts_pkg::mid_type mid_word
);
   logic [31:0] clk_ff;
   logic [9:0]  vol_ff;
   logic [8:0]  tempo_ff;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clk_ff   <= nts_pkg::CLOCK_RESET;
         vol_ff   <= nts_pkg::VOLUME_RESET;
         tempo_ff <= nts_pkg::TEMPO_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            nts_pkg::CSR_SYSTEM_CLOCK: clk_ff   <= csr_wdata;
            nts_pkg::CSR_VOLUME:       vol_ff   <= csr_wdata[9:0];
            nts_pkg::CSR_TEMPO:        tempo_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   // Classify: silence, divider magnitude and dotted flag, tempo floor
   always_comb begin
      mid_word.silent = (req_note_frequency == '0) ||
                        (req_note_frequency > nts_pkg::MAX_AUDIBLE_HZ);
      mid_word.freq   = req_note_frequency;
      mid_word.dotted = req_note_divider[7];
      mid_word.dzero  = (req_note_divider == '0);
      mid_word.den    = req_note_divider[7] ? (~req_note_divider + 8'd1)
                                            : req_note_divider;
      mid_word.tempo  = (tempo_ff == '0) ? 9'd1 : tempo_ff;
      mid_word.clk    = clk_ff;
      mid_word.vol    = vol_ff;
   end
endmodule

// ----- src/nts_back.sv -----
// Back: divider pipeline that turns a classified note into timer settings.
// Depends on nts_pkg and nts_div; constant divisors use reciprocal multiplies.
module nts_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  nts_pkg::mid_type in_word,
   output logic             out_valid,
   output nts_pkg::rsp_type out_word
);
   localparam int S = $bits(nts_pkg::work_type);

   nts_pkg::work_type w0, w6, w7, w7_in, w1, w2, w3_ff, w3_in, w4, w4_in, wm_in, wm_ff;
   nts_pkg::work_type w5_ff;
   logic        v6, v7, v1, v2_ff, v3, v4, vm_ff, v5_ff;
   logic [17:0] q6, q7;
   logic [31:0] q1, q3, q4;
   logic [16:0] q2_ff;
   logic [15:0] q5_ff;
   logic [25:0] prod_ff;
   logic [54:0] presc_prod;
   logic [44:0] duty_prod;

   always_comb begin
      w0 = '0;
      w0.note = in_word;
   end

   // Whole note length
   nts_div #(.N(18), .D(9), .S(S)) u_whole (
      .clock, .reset, .en, .in_valid(in_valid),
      .in_num(nts_pkg::WHOLE_NOTE_BASE_MS), .in_den(w0.note.tempo), .in_side(w0),
      .out_valid(v6), .out_quo(q6), .out_side(w6));

   always_comb begin
      w7_in = w6;
      w7_in.whole = q6;
   end

   // Note length from the divider magnitude
   nts_div #(.N(18), .D(8), .S(S)) u_note (
      .clock, .reset, .en, .in_valid(v6),
      .in_num(q6), .in_den(w6.note.den), .in_side(w7_in),
      .out_valid(v7), .out_quo(q7), .out_side(w7));

   // Add half for dotted notes, drop to zero for a zero divider
   always_comb begin
      w1 = w7;
      if (w7.note.dzero) begin
         w1.dur = '0;
      end else if (w7.note.dotted) begin
         w1.dur = {1'b0, q7} + {2'b0, q7[17:1]};
      end else begin
         w1.dur = {1'b0, q7};
      end
   end

   // Clock over frequency
   nts_div #(.N(32), .D(16), .S(S)) u_clk_freq (
      .clock, .reset, .en, .in_valid(v7),
      .in_num(w1.note.clk), .in_den(w1.note.freq), .in_side(w1),
      .out_valid(v1), .out_quo(q1), .out_side(w2));

   // Prescaler from the period limit by reciprocal multiply
   always_comb begin
      presc_prod = {28'd0, q1[31:5]} * {27'd0, nts_pkg::PRESC_RECIP};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w3_ff <= w2;
         q2_ff <= presc_prod[54:38];
      end
   end

   always_comb begin
      w3_in = w3_ff;
      w3_in.p = q2_ff + 17'd1;
   end

   // Prescaled clock
   nts_div #(.N(32), .D(17), .S(S)) u_clk_presc (
      .clock, .reset, .en, .in_valid(v2_ff),
      .in_num(w3_ff.note.clk), .in_den(w3_in.p), .in_side(w3_in),
      .out_valid(v3), .out_quo(q3), .out_side(w4));

   // Period in timer cycles
   nts_div #(.N(32), .D(16), .S(S)) u_period (
      .clock, .reset, .en, .in_valid(v3),
      .in_num(q3), .in_den(w4.note.freq), .in_side(w4),
      .out_valid(v4), .out_quo(q4), .out_side(w4_in));

   // Volume times period
   always_comb begin
      wm_in = w4_in;
      wm_in.period = q4[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff <= 1'b0;
      end else if (en) begin
         vm_ff <= v4;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wm_ff   <= wm_in;
         prod_ff <= {16'd0, w4_in.note.vol} * {10'd0, q4[15:0]};
      end
   end

   // Pulse width over the duty scale by reciprocal multiply
   always_comb begin
      duty_prod = {23'd0, prod_ff[25:4]} * {22'd0, nts_pkg::DUTY_RECIP};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= vm_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w5_ff <= wm_ff;
         q5_ff <= duty_prod[44:29];
      end
   end

   // Assemble the result, zero timer settings when silent
   always_comb begin
      out_valid              = v5_ff;
      out_word.silent        = w5_ff.note.silent;
      out_word.duration_ms   = w5_ff.dur;
      out_word.prescale_value = '0;
      out_word.reload_value  = '0;
      out_word.compare_value = '0;
      if (!w5_ff.note.silent) begin
         out_word.prescale_value = w5_ff.p - 17'd1;
         out_word.reload_value   = (w5_ff.period == '0) ? '0 : w5_ff.period - 16'd1;
         out_word.compare_value  = q5_ff;
      end
   end
endmodule

// ----- src/note_to_pwm_tone_settings_top.sv -----
// Top level of the note to PWM tone settings block.
// Depends on nts_pkg, nts_front, nts_fifo and nts_back.
//
// Usage:
//   Notes enter on the req_ queue port: a word is taken when req_push is high
//   and req_full is low. Results leave on the rsp_ queue port: the oldest
//   word is shown while rsp_empty is low and is taken when rsp_pop is high.
//   Registers (clock Hz, volume, tempo) are written on csr_ with csr_write_en;
//   write them only while no note is in flight.
// Path: from the accepting edge a word passes the middle queue, the chain of
//   bit-per-stage dividers (18 + 18 + 32 + 32 + 32 stages), one
//   reciprocal-multiply stage each for the prescaler and the duty, one multiply
//   stage and the write into the result queue before it shows on rsp_.
// Throughput: one note per cycle while the result queue has room; every divider
//   stage takes a new word each cycle that the pipe is not held.
// Reset: synchronous and active high; queues and pipeline empty, registers
//   return to 8 MHz, volume 50 and tempo 120.
// Stall: when the result queue fills the whole divider pipe holds; the
//   middle queue then fills and req_full rises.
module note_to_pwm_tone_settings_top #(
   parameter int MID_DEPTH = nts_pkg::MID_DEPTH_DEFAULT,
   parameter int OUT_DEPTH = nts_pkg::OUT_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_push,
   output logic        req_full,
   input  logic [15:0] req_note_frequency,
   input  logic [7:0]  req_note_divider,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_silent,
   output logic [16:0] rsp_prescale_value,
   output logic [15:0] rsp_reload_value,
   output logic [15:0] rsp_compare_value,
   output logic [18:0] rsp_duration_ms
);
   nts_pkg::mid_type mid_push_word, mid_pop_word;
   nts_pkg::rsp_type back_word, rsp_word;
   logic mid_empty, back_en, back_valid, out_full;

   nts_front u_front (
      .clock, .reset, .csr_write_en, .csr_index, .csr_wdata,
      .req_note_frequency, .req_note_divider, .mid_word(mid_push_word));

   nts_fifo #(.WIDTH($bits(nts_pkg::mid_type)), .DEPTH(MID_DEPTH)) u_mid_q (
      .clock, .reset,
      .push(req_push), .push_data(mid_push_word), .full(req_full),
      .pop(back_en), .pop_data(mid_pop_word), .empty(mid_empty));

   // Advance the back pipe while the result queue has room
   assign back_en = !out_full;

   nts_back u_back (
      .clock, .reset, .en(back_en), .in_valid(!mid_empty),
      .in_word(mid_pop_word), .out_valid(back_valid), .out_word(back_word));

   nts_fifo #(.WIDTH($bits(nts_pkg::rsp_type)), .DEPTH(OUT_DEPTH)) u_out_q (
      .clock, .reset,
      .push(back_en && back_valid), .push_data(back_word), .full(out_full),
      .pop(rsp_pop), .pop_data(rsp_word), .empty(rsp_empty));

   assign rsp_silent         = rsp_word.silent;
   assign rsp_prescale_value = rsp_word.prescale_value;
   assign rsp_reload_value   = rsp_word.reload_value;
   assign rsp_compare_value  = rsp_word.compare_value;
   assign rsp_duration_ms    = rsp_word.duration_ms;
endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for note_to_pwm_tone_settings_top.
// Drives notes through the req_ queue, predicts timer settings and note length
// in the bench, and checks each rsp_ word in order. Depends on nts_pkg.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock;
   logic        reset;
   logic        csr_write_en;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;
   logic        req_push;
   logic        req_full;
   logic [15:0] req_note_frequency;
   logic [7:0]  req_note_divider;
   logic        rsp_empty;
   logic        rsp_pop;
   logic        rsp_silent;
   logic [16:0] rsp_prescale_value;
   logic [15:0] rsp_reload_value;
   logic [15:0] rsp_compare_value;
   logic [18:0] rsp_duration_ms;

   note_to_pwm_tone_settings_top dut (.*);

   // Bench copy of the registers
   logic [31:0] clk_hz;
   logic [9:0]  vol;
   logic [8:0]  tempo;

   nts_pkg::rsp_type settings_q[$];
   int          err_count;
   longint      cycles;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // Work out the settings for one note
   function automatic nts_pkg::rsp_type tone_settings(logic [15:0] f, logic [7:0] dv);
      nts_pkg::rsp_type r;
      longint unsigned p, per, whole, d, m;
      r = '0;
      if (f == 16'd0 || f > 16'd20000) r.silent = 1'b1;
      else begin
         p = 1 + (longint'(clk_hz) / f) / 60000;
         per = (longint'(clk_hz) / p) / f;
         r.prescale_value = 17'(p - 1);
         r.reload_value = (per != 0) ? 16'(per - 1) : 16'd0;
         r.compare_value = 16'((longint'(vol) * per) / 2000);
      end
      whole = 240000 / ((tempo != 9'd0) ? tempo : 9'd1);
      if (dv == 8'd0) r.duration_ms = 19'd0;
      else if (!dv[7]) r.duration_ms = 19'(whole / dv);
      else begin
         m = 256 - dv;
         d = whole / m;
         r.duration_ms = 19'(d + d / 2);
      end
      return r;
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      err_count++;
   endtask

   // Receiver: stall on its own pattern, check each popped word
   initial begin
      int mode;
      rsp_pop = 0;
      forever begin
         @(negedge clock);
         mode = int'((cycles / 700) % 3);
         rsp_pop <= (mode == 0) ? 1'b1 : (mode == 1) ? ($urandom_range(3) != 0)
                                                    : ($urandom_range(3) == 0);
      end
   end

   always @(posedge clock) begin
      nts_pkg::rsp_type w;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (settings_q.size() == 0) report("unexpected word", 0, 0);
         else begin
            w = settings_q.pop_front();
            if (rsp_silent !== w.silent)
               report("silent", longint'(rsp_silent), longint'(w.silent));
            if (rsp_prescale_value !== w.prescale_value)
               report("prescale", longint'(rsp_prescale_value),
                      longint'(w.prescale_value));
            if (rsp_reload_value !== w.reload_value)
               report("reload", longint'(rsp_reload_value), longint'(w.reload_value));
            if (rsp_compare_value !== w.compare_value)
               report("compare", longint'(rsp_compare_value),
                      longint'(w.compare_value));
            if (rsp_duration_ms !== w.duration_ms)
               report("duration", longint'(rsp_duration_ms), longint'(w.duration_ms));
         end
      end
   end

   // Send one note; hold push high across back-to-back words
   task automatic send_note(logic [15:0] f, logic [7:0] dv);
      req_push <= 1'b1;
      req_note_frequency <= f;
      req_note_divider <= dv;
      @(posedge clock);
      while (req_full) @(posedge clock);
      settings_q.push_back(tone_settings(f, dv));
      @(negedge clock);
   endtask

   task automatic idle_sender(int n);
      req_push <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         nts_pkg::CSR_SYSTEM_CLOCK: clk_hz = val;
         nts_pkg::CSR_VOLUME:       vol = val[9:0];
         default:                   tempo = val[8:0];
      endcase
   endtask

   // Wait for all words, then past the pipe latency
   task automatic drain();
      req_push <= 1'b0;
      while (settings_q.size() != 0) @(negedge clock);
      repeat (250) @(negedge clock);
   endtask

   task automatic random_notes(int n);
      int burst;
      while (n > 0) begin
         burst = $urandom_range(40, 1);
         repeat (burst) begin
            case ($urandom_range(9))
               0: send_note(16'($urandom), 8'($urandom));
               1: send_note($urandom_range(1, 0) ? 16'd0
                                                 : 16'($urandom_range(65535, 20001)),
                            8'($urandom));
               2: send_note(16'($urandom_range(20000, 1)), 8'($urandom));
               default: send_note(16'($urandom_range(5000, 1)),
                                  8'($urandom_range(128, 0) - 64));
            endcase
            n--;
         end
         if ($urandom_range(2) != 0) idle_sender($urandom_range(12, 1));
      end
   endtask

   task automatic test_directed();
      logic [7:0] dvs[10] = '{8'd0, 8'd1, 8'd64, 8'd127, 8'h80, 8'hFF, 8'hC0,
                              8'd4, 8'hFC, 8'h55};
      foreach (dvs[i]) send_note(16'd440, dvs[i]);
      send_note(16'd0, 8'd4);
      send_note(16'd1, 8'd1);
      send_note(16'd20000, 8'd2);
      send_note(16'd20001, 8'd8);
      send_note(16'hFFFF, 8'hAA);
      send_note(16'd2, 8'd16);
      drain();
   endtask

   task automatic test_settings();
      logic [31:0] clks[4] = '{32'd1000000, 32'hFFFFFFFF, 32'd12345, 32'd72000000};
      logic [9:0]  vols[4] = '{10'd0, 10'd1000, 10'd1023, 10'd333};
      logic [8:0]  tempos[4] = '{9'd1, 9'd400, 9'd0, 9'd511};
      foreach (clks[i]) begin
         write_reg(nts_pkg::CSR_SYSTEM_CLOCK, clks[i]);
         write_reg(nts_pkg::CSR_VOLUME, 32'(vols[i]));
         write_reg(nts_pkg::CSR_TEMPO, 32'(tempos[i]));
         send_note(16'd1, 8'hC0);
         send_note(16'd20000, 8'd1);
         random_notes(150);
         drain();
      end
   endtask

   task automatic test_random();
      repeat (4) begin
         write_reg(nts_pkg::CSR_SYSTEM_CLOCK, $urandom);
         write_reg(nts_pkg::CSR_VOLUME, $urandom_range(1023));
         write_reg(nts_pkg::CSR_TEMPO, $urandom_range(511));
         random_notes(225);
         drain();
      end
   endtask

   initial begin
      reset = 1;
      cycles = 0;
      err_count = 0;
      csr_write_en = 0;
      csr_index = nts_pkg::CSR_SYSTEM_CLOCK;
      csr_wdata = 0;
      req_push = 0;
      req_note_frequency = 0;
      req_note_divider = 0;
      clk_hz = nts_pkg::CLOCK_RESET;
      vol = nts_pkg::VOLUME_RESET;
      tempo = nts_pkg::TEMPO_RESET;
      repeat (10) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      test_directed();
      test_settings();
      test_random();
      if (err_count == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end
endmodule
